>>> sv/vsrc_pkg.sv
package vsrc_pkg;

  // item operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // tick sources
  localparam logic [1:0] SRC_SYSTEM = 2'd0;
  localparam logic [1:0] SRC_HBLANK = 2'd1;
  localparam logic [1:0] SRC_VBLANK = 2'd2;

  // register offsets
  localparam logic [3:0] OFF_COUNT  = 4'd0;
  localparam logic [3:0] OFF_MODE   = 4'd4;
  localparam logic [3:0] OFF_TARGET = 4'd8;

  // mode word bit positions
  localparam int SYNC_LO  = 1;
  localparam int SYNC_HI  = 2;
  localparam int RST_BIT  = 3;
  localparam int SRC_BIT  = 8;
  localparam int TGT_FLAG = 11;
  localparam int WRAP_FLAG = 12;

  localparam logic [1:0]  SYNC_WAIT = 2'd3;
  localparam logic [15:0] COUNT_MAX = 16'hffff;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  tick_source;
    logic [3:0]  reg_offset;
    logic [15:0] write_data;
  } vsrc_item_t;

endpackage

>>> sv/vsrc_core.sv
module vsrc_core import vsrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  vsrc_item_t  item,
  output logic [15:0] result
);

  logic [15:0] count_value, count_value_next;
  logic [15:0] mode_word, mode_word_next;
  logic [15:0] target_value, target_value_next;
  logic        wait_vblank, wait_vblank_next;

  logic [1:0] selected;
  logic       rot;

  assign selected = {1'b0, mode_word[SRC_BIT]};
  assign rot      = mode_word[RST_BIT];

  always_comb begin
    count_value_next  = count_value;
    mode_word_next    = mode_word;
    target_value_next = target_value;
    wait_vblank_next  = wait_vblank;
    result            = '0;
    if (fire) begin
      case (item.mode)
        OP_TICK: begin
          if (wait_vblank) begin
            if (item.tick_source == SRC_VBLANK) begin
              wait_vblank_next = 1'b0;
              count_value_next = '0;
            end
          end else if (item.tick_source == selected) begin
            if (rot && count_value == target_value) begin
              mode_word_next[TGT_FLAG] = 1'b1;
              count_value_next         = '0;
            end else if (!rot && count_value == COUNT_MAX) begin
              mode_word_next[WRAP_FLAG] = 1'b1;
              count_value_next          = '0;
            end else begin
              count_value_next = count_value + 16'd1;
            end
          end
        end
        OP_READ: begin
          if (item.reg_offset == OFF_COUNT) begin
            result = count_value;
          end else if (item.reg_offset == OFF_MODE) begin
            result                    = mode_word;
            mode_word_next[TGT_FLAG]  = 1'b0;
            mode_word_next[WRAP_FLAG] = 1'b0;
          end else if (item.reg_offset == OFF_TARGET) begin
            result = target_value;
          end
        end
        OP_WRITE: begin
          if (item.reg_offset == OFF_COUNT) begin
            count_value_next = item.write_data;
          end else if (item.reg_offset == OFF_MODE) begin
            mode_word_next = item.write_data;
            if (item.write_data[SYNC_HI:SYNC_LO] == SYNC_WAIT) begin
              wait_vblank_next = 1'b1;
            end
          end else if (item.reg_offset == OFF_TARGET) begin
            target_value_next = item.write_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value  <= '0;
      mode_word    <= '0;
      target_value <= '0;
      wait_vblank  <= 1'b0;
    end else begin
      count_value  <= count_value_next;
      mode_word    <= mode_word_next;
      target_value <= target_value_next;
      wait_vblank  <= wait_vblank_next;
    end
  end

endmodule

>>> sv/video_sync_root_counter.sv
// Root counter with target: one transaction per item in, one result transaction
// per item out. Items are clock ticks (system, hblank or vblank source) or
// 16-bit register accesses at offset 0 (count), 4 (mode) and 8 (target). The
// block takes one item every clock cycle while results are taken. A result is
// offered once its item has passed the input register and the result register,
// with the state update (compare plus increment) made as the item moves from
// one to the other. A stalled output holds two items (input register plus
// result register) before in_ready drops.
// Reading the mode register returns the flags and clears them; a mode write
// with sync mode 3 makes the counter ignore ticks until a vblank tick, which
// clears it. read_data is 0 for ticks, writes, unused op codes and unknown offsets.
module video_sync_root_counter import vsrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [1:0]  tick_source,
  input  logic [3:0]  reg_offset,
  input  logic [15:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data
);

  // input register
  logic       held;
  vsrc_item_t item;

  // result register
  logic        out_full;
  logic [15:0] out_data;

  logic        advance;
  logic [15:0] result;

  // an item moves to the result register when that slot is free or draining
  assign advance  = held && (!out_full || out_ready);
  assign in_ready = !held || advance;

  assign out_valid = out_full;
  assign read_data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (in_ready) begin
        held <= in_valid;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.mode        <= mode;
      item.tick_source <= tick_source;
      item.reg_offset  <= reg_offset;
      item.write_data  <= write_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  // state update happens once, as the item leaves the input register
  vsrc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .result (result)
  );

endmodule

>>> sv/vsrc_checker.sv
module vsrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] read_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("result changed while stalled");

  // input stalls only when the result slot is full and not draining
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // an accepted transaction is always followed by a pending result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result after accepted transaction");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind video_sync_root_counter vsrc_checker u_vsrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .read_data (read_data)
);

>>> test/vsrc_tb_pkg.sv
package vsrc_tb_pkg;
  import vsrc_pkg::*;

  // Holds an item-level copy of the root counter's state. Each accepted item
  // updates that copy and queues the read_data value the block should return.
  class root_counter_scoreboard;
    logic [15:0] count_q;
    logic [15:0] mode_q;
    logic [15:0] target_q;
    bit          vblank_wait;
    logic [15:0] pending_reads[$];
    int          errors;
    int          checked;
    int          counted_ticks;
    int          target_hits;
    int          wraps;
    int          waits_armed;

    function new();
      count_q       = '0;
      mode_q        = '0;
      target_q      = '0;
      vblank_wait   = 1'b0;
      errors        = 0;
      checked       = 0;
      counted_ticks = 0;
      target_hits   = 0;
      wraps         = 0;
      waits_armed   = 0;
    endfunction

    function void apply_tick(logic [1:0] src);
      logic [1:0] selected;
      if (vblank_wait) begin
        if (src == SRC_VBLANK) begin
          vblank_wait = 1'b0;
          count_q     = '0;
        end
        return;
      end
      selected = mode_q[SRC_BIT] ? SRC_HBLANK : SRC_SYSTEM;
      if (src != selected) return;
      counted_ticks++;
      if (mode_q[RST_BIT] && count_q == target_q) begin
        mode_q[TGT_FLAG] = 1'b1;
        count_q = '0;
        target_hits++;
      end else if (!mode_q[RST_BIT] && count_q == COUNT_MAX) begin
        mode_q[WRAP_FLAG] = 1'b1;
        count_q = '0;
        wraps++;
      end else begin
        count_q = count_q + 16'd1;
      end
    endfunction

    function void note_item(logic [1:0] op, logic [1:0] src, logic [3:0] off,
                            logic [15:0] data);
      logic [15:0] value;
      value = '0;
      case (op)
        OP_TICK: apply_tick(src);
        OP_READ: begin
          case (off)
            OFF_COUNT:  value = count_q;
            OFF_MODE: begin
              value = mode_q;
              mode_q[TGT_FLAG]  = 1'b0;
              mode_q[WRAP_FLAG] = 1'b0;
            end
            OFF_TARGET: value = target_q;
            default:    value = '0;
          endcase
        end
        OP_WRITE: begin
          case (off)
            OFF_COUNT: count_q = data;
            OFF_MODE: begin
              mode_q = data;
              if (data[SYNC_HI:SYNC_LO] == SYNC_WAIT) begin
                vblank_wait = 1'b1;
                waits_armed++;
              end
            end
            OFF_TARGET: target_q = data;
            default: ;
          endcase
        end
        default: ;
      endcase
      pending_reads.push_back(value);
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual read_data=%h", $time, got);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: read_data mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return pending_reads.size();
    endfunction
  endclass

endpackage

>>> test/tb_video_sync_root_counter.sv
module tb_video_sync_root_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import vsrc_pkg::*;
  import vsrc_tb_pkg::*;

  // codes the block treats as no-ops
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] SRC_UNUSED = 2'd3;
  localparam logic [3:0] OFF_UNUSED = 4'hf;

  localparam int RANDOM_ITEMS = 1950;
  localparam int SECTION      = 200;     // idling switches on/off per section
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 400000;  // watchdog limit on total cycles

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [1:0]  tick_source;
  logic [3:0]  reg_offset;
  logic [15:0] write_data;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] read_data;

  root_counter_scoreboard sb;
  bit idling;        // shared by sender and receiver: random gaps/stalls on
  bit hold_done;
  int cycles;

  video_sync_root_counter i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .tick_source (tick_source),
    .reg_offset  (reg_offset),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycles, sb.pending());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one input transaction. Payload goes out on the falling edge; the
  // handshake is sampled on the rising edge. Valid is held until accepted.
  task automatic send_item(logic [1:0] op, logic [1:0] src, logic [3:0] off,
                           logic [15:0] data);
    int gap;
    gap = idling ? $urandom_range(0, 17) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    mode        <= op;
    tick_source <= src;
    reg_offset  <= off;
    write_data  <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, src, off, data);
  endtask

  // Sender pause: hold off until every queued result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One random item. Mostly ticks, with register traffic biased toward
  // values that make target hits and 0xFFFF wraps actually happen.
  task automatic send_random();
    logic [1:0]  op;
    logic [1:0]  src;
    logic [3:0]  off;
    logic [15:0] data;
    int          pick;
    pick = $urandom_range(0, 99);
    op   = pick < 55 ? OP_TICK : pick < 75 ? OP_READ : pick < 95 ? OP_WRITE : OP_UNUSED;
    pick = $urandom_range(0, 9);
    src  = pick < 4 ? SRC_SYSTEM : pick < 7 ? SRC_HBLANK : pick < 9 ? SRC_VBLANK : SRC_UNUSED;
    pick = $urandom_range(0, 9);
    off  = pick < 3 ? OFF_COUNT : pick < 6 ? OFF_MODE : pick < 8 ? OFF_TARGET
                    : 4'($urandom_range(0, 15));
    data = 16'($urandom_range(0, 65535));
    if (op == OP_WRITE) begin
      pick = $urandom_range(0, 9);
      if (off == OFF_COUNT && pick < 4)
        data = COUNT_MAX - 16'($urandom_range(0, 8));
      else if (off == OFF_COUNT && pick < 7)
        data = 16'($urandom_range(0, 10));
      else if (off == OFF_TARGET && pick < 6)
        data = 16'($urandom_range(0, 12));
      else if (off == OFF_MODE && pick < 3)
        data[SYNC_HI:SYNC_LO] = SYNC_WAIT;   // arm the vblank wait more often
    end
    // Field values of other ops are don't-care but still randomized.
    send_item(op, src, off, data);
  endtask

  // Receiver: random stalls per result, plus one long hold-off mid-run while
  // the sender keeps pushing, so the pipeline fills and in_ready drops.
  initial begin
    int stall;
    @(negedge clk);
    wait (rst == 1'b0);
    forever begin
      if (!hold_done && sb.checked >= 800) begin
        hold_done = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end
      stall = idling ? $urandom_range(0, 17) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(read_data);
    end
  end

  initial begin
    sb          = new();
    idling      = 1'b1;
    hold_done   = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    mode        = OP_TICK;
    tick_source = SRC_SYSTEM;
    reg_offset  = OFF_COUNT;
    write_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed: reset values, target hit, wrap, flag clear, vblank wait
    send_item(OP_READ,  SRC_SYSTEM, OFF_COUNT,  16'h0000);
    send_item(OP_READ,  SRC_SYSTEM, OFF_MODE,   16'h0000);
    send_item(OP_READ,  SRC_SYSTEM, OFF_TARGET, 16'h0000);
    send_item(OP_WRITE, SRC_SYSTEM, OFF_TARGET, 16'h0003);
    send_item(OP_WRITE, SRC_SYSTEM, OFF_MODE,   16'h0008);  // reset-on-target
    repeat (4) send_item(OP_TICK, SRC_SYSTEM, OFF_COUNT, 16'h0000); // 3 -> 0, flag
    send_item(OP_TICK,  SRC_HBLANK, OFF_COUNT,  16'h0000);  // wrong source
    send_item(OP_READ,  SRC_SYSTEM, OFF_MODE,   16'h0000);  // flag, then cleared
    send_item(OP_WRITE, SRC_SYSTEM, OFF_COUNT,  COUNT_MAX);
    send_item(OP_WRITE, SRC_SYSTEM, OFF_MODE,   16'h0000);
    send_item(OP_TICK,  SRC_SYSTEM, OFF_COUNT,  16'h0000);  // wrap flag
    send_item(OP_WRITE, SRC_SYSTEM, OFF_COUNT,  COUNT_MAX);
    // hblank source, reset-on-target, both flag bits written directly
    send_item(OP_WRITE, SRC_SYSTEM, OFF_MODE,   16'h1908);
    send_item(OP_TICK,  SRC_HBLANK, OFF_COUNT,  16'h0000);  // silent wrap to 0
    send_item(OP_READ,  SRC_SYSTEM, OFF_MODE,   16'h0000);
    send_item(OP_WRITE, SRC_SYSTEM, OFF_MODE,   16'h0006);  // sync mode 3: wait
    send_item(OP_TICK,  SRC_HBLANK, OFF_COUNT,  16'h0000);  // ignored while waiting
    send_item(OP_TICK,  SRC_UNUSED, OFF_COUNT,  16'h0000);  // never ends a wait
    send_item(OP_TICK,  SRC_VBLANK, OFF_COUNT,  16'h0000);  // clears, ends wait
    send_item(OP_WRITE, SRC_SYSTEM, OFF_UNUSED, 16'hffff);  // ignored write
    send_item(OP_UNUSED, SRC_UNUSED, OFF_UNUSED, 16'hffff); // no-op item
    send_item(OP_READ,  SRC_SYSTEM, OFF_UNUSED, 16'h0000);  // reads 0

    // --- random: idling on for two sections, off for the third
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idling = ((n / SECTION) % 3) != 2;
      if (n == 500) wait_drained();
      send_random();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then keep the clock running so that stray results still show up.
    do @(posedge clk); while (sb.pending() != 0);
    repeat (10) @(posedge clk);

    $display("checked %0d results: %0d counted ticks, %0d target hits, %0d wraps,",
             sb.checked, sb.counted_ticks, sb.target_hits, sb.wraps);
    $display("%0d vblank waits armed, one long output hold-off", sb.waits_armed);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
